// File: src/ile_pkg.sv
// Package for the integer list engine: command and status codes, FSM states, defaults.
package ile_pkg;

    localparam int DEF_CAPACITY = 32;

    localparam logic [3:0] CMD_LIST  = 4'd0;
    localparam logic [3:0] CMD_APPND = 4'd1;
    localparam logic [3:0] CMD_REMV  = 4'd2;
    localparam logic [3:0] CMD_REMI  = 4'd3;
    localparam logic [3:0] CMD_CLEAR = 4'd4;
    localparam logic [3:0] CMD_MEAN  = 4'd5;
    localparam logic [3:0] CMD_FIND  = 4'd6;
    localparam logic [3:0] CMD_MIN   = 4'd7;
    localparam logic [3:0] CMD_MAX   = 4'd8;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_BADINDEX = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_EMIT
    } state_t;

endpackage

// File: src/ile_cell.sv
// One storage cell of the entry chain: load, shift from right neighbor, or hold.
module ile_cell
    import ile_pkg::*;
(
    input  logic        clk,
    input  logic        shift_en,
    input  logic        load_en,
    input  logic [31:0] load_data,
    input  logic [31:0] right_data,
    output logic [31:0] value
);

    logic [31:0] value_reg;
    logic [31:0] value_next;

    always_comb
    begin
        if (load_en)
        begin
            value_next = load_data;
        end
        else if (shift_en)
        begin
            value_next = right_data;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: src/ile_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module ile_divider
    import ile_pkg::*;
#(
    parameter int DW = 45,
    parameter int CW = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [CW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int NW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [DW-1:0] quo_next;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic [CW-1:0] dsr_reg;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW:0]   rem_sh;
    logic [CW:0]   rem_sub;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DW-1]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = NW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sub[CW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[CW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/integer_list_engine.sv
// Top level of the integer list engine: command FSM, entry chain and mean divider.
// Usage: one command item enters on in_valid/in_ready; results leave on
// out_valid/out_ready through an output register. The engine works on one
// command at a time; in_ready is high only while the FSM is idle, so the next
// command is taken at the earliest in the cycle after the last result is loaded.
// The entries live in a chain of CAPACITY cells. A scan shifts the chain
// toward cell 0 once per cycle unless the receiver stalls; the head entry is
// examined and, if kept, reloaded at the tail of the live list, so after n steps
// (n = entry count) the list is back in order, with removed entries closed up.
// Result paths, n entries:
//   clear, append, empty, bad index, full: straight from idle to the emit state.
//   list: n results, one per cycle when the receiver keeps out_ready high.
//   remove by value or index, find, smallest, largest: n scan steps, then emit.
//   mean: n scan steps, a registered divider start, a restoring divide with a
//   (32+log2 CAPACITY+8)-bit quotient, then the emit state and the result.
// A receiver stall freezes the chain: no scan step and no emit is taken
// while the output register holds an item that is not taken.
// Reset clears the FSM, the entry count and the output valid; entry
// contents are not reset and are only read below the entry count.
// Unknown commands (9 to 15) are taken and dropped with no result.
module integer_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         cmd,
    input  logic signed [31:0] operand_value,
    input  logic [5:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] item_value,
    output logic [5:0]         item_index,
    output logic signed [39:0] mean_q8,
    output logic [6:0]         entry_count,
    output logic               last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = 32 + IW;
    localparam int DW = SW + 8;

    // FSM and command registers
    state_t        state_reg, state_next;
    logic [3:0]    cmd_reg;
    logic [31:0]   val_reg;
    logic [5:0]    pos_reg;
    logic [2:0]    stat_reg;
    logic [2:0]    stat_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] len_next;
    logic [IW-1:0] k_reg;
    logic          found_reg;
    logic [IW-1:0] fidx_reg;
    logic [31:0]   acc_reg;
    logic signed [SW-1:0] sum_reg;
    logic          div_go_reg;

    // output register
    logic          out_valid_reg;
    logic [2:0]    o_stat_reg;
    logic [31:0]   o_val_reg;
    logic [5:0]    o_idx_reg;
    logic [39:0]   o_mean_reg;
    logic [6:0]    o_cnt_reg;
    logic          o_last_reg;

    logic          accept;
    logic          out_free;
    logic          step;
    logic          last_step;
    logic          keep;
    logic          emit;
    logic [31:0]   head;
    logic [31:0]   cell_val [CAPACITY];
    logic          div_start;
    logic          div_done;
    logic [DW-1:0] div_q;
    logic          sum_neg;
    logic [SW-1:0] sum_mag;
    logic [63:0]   q_ext;
    logic [63:0]   q_signed;
    logic [2:0]    e_stat;
    logic [31:0]   e_val;
    logic [5:0]    e_idx;
    logic [39:0]   e_mean;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign step     = (state_reg == S_SCAN) && out_free;
    assign emit     = (state_reg == S_EMIT) && out_free;
    assign head     = cell_val[0];
    assign last_step = (CW'(k_reg) == fill_reg - CW'(1));

    always_comb
    begin
        unique case (cmd_reg)
            CMD_REMV: keep = (head != val_reg);
            CMD_REMI: keep = (7'(k_reg) != 7'(pos_reg));
            default:  keep = 1'b1;
        endcase
    end

    // entry chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic ld;
            assign ld = (step && keep && (CW'(gi) == len_reg - CW'(1)))
                     || (emit && (cmd_reg == CMD_APPND) && (stat_reg == STAT_OK)
                         && (CW'(gi) == fill_reg));
            ile_cell u_cell
            (
                .clk        (clk),
                .shift_en   (step),
                .load_en    (ld),
                .load_data  (step ? head : val_reg),
                .right_data ((gi == CAPACITY - 1) ? head : cell_val[(gi + 1) % CAPACITY]),
                .value      (cell_val[gi])
            );
        end
    endgenerate

    // mean divider
    assign sum_neg   = sum_reg[SW-1];
    assign sum_mag   = sum_neg ? SW'(-sum_reg) : SW'(sum_reg);
    assign div_start = (state_reg == S_DIV) && div_go_reg;

    ile_divider #(.DW(DW), .CW(CW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_mag, 8'b0}),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_ext    = 64'(div_q);
    assign q_signed = sum_neg ? (64'd0 - q_ext) : q_ext;

    // status decided at accept time
    always_comb
    begin
        if (cmd == CMD_CLEAR)
        begin
            stat_next = STAT_OK;
        end
        else if (cmd == CMD_APPND)
        begin
            stat_next = (fill_reg == CW'(CAPACITY)) ? STAT_FULL : STAT_OK;
        end
        else if (fill_reg == '0)
        begin
            stat_next = STAT_EMPTY;
        end
        else if ((cmd == CMD_REMI) && (7'(position) >= 7'(fill_reg)))
        begin
            stat_next = STAT_BADINDEX;
        end
        else
        begin
            stat_next = STAT_OK;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd <= CMD_MAX))
                begin
                    if ((cmd == CMD_CLEAR) || (cmd == CMD_APPND) || (stat_next != STAT_OK))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (step && last_step)
                begin
                    if (cmd_reg == CMD_LIST)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (cmd_reg == CMD_MEAN)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // emit fields and new entry count
    always_comb
    begin
        e_stat    = stat_reg;
        e_val     = '0;
        e_idx     = '0;
        e_mean    = '0;
        fill_next = fill_reg;
        if (stat_reg == STAT_OK)
        begin
            unique case (cmd_reg)
                CMD_CLEAR: fill_next = '0;
                CMD_APPND:
                begin
                    e_val     = val_reg;
                    e_idx     = 6'(fill_reg);
                    fill_next = fill_reg + CW'(1);
                end
                CMD_REMV: fill_next = len_reg;
                CMD_REMI:
                begin
                    e_val     = acc_reg;
                    e_idx     = pos_reg;
                    fill_next = len_reg;
                end
                CMD_MEAN: e_mean = q_signed[39:0];
                CMD_FIND:
                begin
                    if (found_reg)
                    begin
                        e_val = val_reg;
                        e_idx = 6'(fidx_reg);
                    end
                    else
                    begin
                        e_stat = STAT_NOTFOUND;
                    end
                end
                CMD_MIN, CMD_MAX: e_val = acc_reg;
                default: e_val = '0;
            endcase
        end
    end

    assign len_next = keep ? len_reg : len_reg - CW'(1);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                fill_reg <= fill_next;
            end
            if (emit || (step && (cmd_reg == CMD_LIST)))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            div_go_reg <= (state_reg == S_SCAN) && (state_next == S_DIV);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            val_reg  <= operand_value;
            pos_reg  <= position;
            stat_reg <= stat_next;
            len_reg  <= fill_reg;
            k_reg    <= '0;
            found_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else if (step)
        begin
            len_reg <= len_next;
            k_reg   <= k_reg + IW'(1);
            sum_reg <= sum_reg + SW'($signed(head));
            if (!found_reg && (head == val_reg))
            begin
                found_reg <= 1'b1;
                fidx_reg  <= k_reg;
            end
            priority if (cmd_reg == CMD_REMI)
            begin
                if (!keep)
                begin
                    acc_reg <= head;
                end
            end
            else if (k_reg == '0)
            begin
                acc_reg <= head;
            end
            else if ((cmd_reg == CMD_MIN) && ($signed(head) < $signed(acc_reg)))
            begin
                acc_reg <= head;
            end
            else if ((cmd_reg == CMD_MAX) && ($signed(head) > $signed(acc_reg)))
            begin
                acc_reg <= head;
            end
            else
            begin
                acc_reg <= acc_reg;
            end
        end
        if (step && (cmd_reg == CMD_LIST))
        begin
            o_stat_reg <= STAT_OK;
            o_val_reg  <= head;
            o_idx_reg  <= 6'(k_reg);
            o_mean_reg <= '0;
            o_cnt_reg  <= 7'(fill_reg);
            o_last_reg <= last_step;
        end
        else if (emit)
        begin
            o_stat_reg <= e_stat;
            o_val_reg  <= e_val;
            o_idx_reg  <= e_idx;
            o_mean_reg <= e_mean;
            o_cnt_reg  <= 7'(fill_next);
            o_last_reg <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = o_stat_reg;
    assign item_value  = o_val_reg;
    assign item_index  = o_idx_reg;
    assign mean_q8     = o_mean_reg;
    assign entry_count = o_cnt_reg;
    assign last        = o_last_reg;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the integer list engine: list model, random and directed commands.
`timescale 1ns / 1ps

module tb;
    import ile_pkg::*;

    localparam int CAP = DEF_CAPACITY;

    // one result item as the block presents it
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value;
        logic [5:0]         index;
        logic signed [39:0] mean;
        logic [6:0]         count;
        logic               last;
    } list_result_t;

    // Scoreboard: keeps its own copy of the list and a queue of pending results.
    class list_scoreboard;
        logic signed [31:0] shadow[CAP];
        int                 fill;
        list_result_t       pending[$];
        int                 errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function void push(logic [2:0] st, logic signed [31:0] v, int idx,
                           logic signed [39:0] m, bit lst);
            list_result_t r;
            r.status = st;
            r.value = v;
            r.index = idx[5:0];
            r.mean = m;
            r.count = fill[6:0];
            r.last = lst;
            pending = {pending, r};
        endfunction

        // work out the results of one accepted command and update the list
        function void note_command(logic [3:0] c, logic signed [31:0] v, logic [5:0] p);
            int j;
            int hit;
            logic signed [63:0] sum;
            logic [63:0] mag;
            logic [63:0] q;
            logic signed [31:0] best;
            if (c > CMD_MAX)
                return;
            if (c == CMD_CLEAR)
            begin
                fill = 0;
                push(STAT_OK, 0, 0, 0, 1);
                return;
            end
            if (c == CMD_APPND)
            begin
                if (fill >= CAP)
                begin
                    push(STAT_FULL, 0, 0, 0, 1);
                    return;
                end
                shadow[fill] = v;
                fill++;
                push(STAT_OK, v, fill - 1, 0, 1);
                return;
            end
            if (fill == 0)
            begin
                push(STAT_EMPTY, 0, 0, 0, 1);
                return;
            end
            case (c)
                CMD_LIST:
                    for (int i = 0; i < fill; i++)
                        push(STAT_OK, shadow[i], i, 0, i + 1 == fill);
                CMD_REMV:
                begin
                    j = 0;
                    for (int i = 0; i < fill; i++)
                        if (shadow[i] != v)
                        begin
                            shadow[j] = shadow[i];
                            j++;
                        end
                    fill = j;
                    push(STAT_OK, 0, 0, 0, 1);
                end
                CMD_REMI:
                begin
                    if (p >= fill)
                        push(STAT_BADINDEX, 0, 0, 0, 1);
                    else
                    begin
                        best = shadow[p];
                        for (int i = p; i + 1 < fill; i++)
                            shadow[i] = shadow[i + 1];
                        fill--;
                        push(STAT_OK, best, p, 0, 1);
                    end
                end
                CMD_MEAN:
                begin
                    sum = 0;
                    for (int i = 0; i < fill; i++)
                        sum += 64'(shadow[i]);
                    mag = (sum < 0) ? 64'(-sum) : 64'(sum);
                    q = (mag * 256) / 64'(fill);
                    if (sum < 0)
                        q = -q;
                    push(STAT_OK, 0, 0, q[39:0], 1);
                end
                CMD_FIND:
                begin
                    hit = -1;
                    for (int i = fill - 1; i >= 0; i--)
                        if (shadow[i] == v)
                            hit = i;
                    if (hit < 0)
                        push(STAT_NOTFOUND, 0, 0, 0, 1);
                    else
                        push(STAT_OK, v, hit, 0, 1);
                end
                default:
                begin
                    best = shadow[0];
                    for (int i = 1; i < fill; i++)
                        if (c == CMD_MIN ? shadow[i] < best : shadow[i] > best)
                            best = shadow[i];
                    push(STAT_OK, best, 0, 0, 1);
                end
            endcase
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected st=%0d v=%0d i=%0d m=%0d n=%0d l=%0d,",
                             want.status, want.value, want.index, want.mean,
                             want.count, want.last,
                             " got st=%0d v=%0d i=%0d m=%0d n=%0d l=%0d",
                             got.status, got.value, got.index, got.mean,
                             got.count, got.last);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [3:0]         cmd = CMD_CLEAR;
    logic signed [31:0] operand_value = '0;
    logic [5:0]         position = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] item_value;
    logic [5:0]         item_index;
    logic signed [39:0] mean_q8;
    logic [6:0]         entry_count;
    logic               last;

    list_scoreboard board = new();
    bit             steady = 0;   // no idling on either side while set
    bit             stim_done = 0;

    integer_list_engine #(.CAPACITY(CAP)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results are sampled at the rising edge; out_ready changes at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({status, item_value, item_index, mean_q8, entry_count, last});
    end

    always @(negedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 17);
    end

    // Drive one command; valid stays high until the block takes it and drops
    // only while idling.
    task automatic send_command(logic [3:0] c, logic signed [31:0] v, logic [5:0] p);
        while (!steady && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= c;
        operand_value <= v;
        position <= p;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_command(c, v, p);
        @(negedge clk);
    endtask

    // Values drawn from a small pool so that removes and finds hit often.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(7) - 4;
            1: return 32'sh7fffffff - $urandom_range(2);
            2: return 32'sh80000000 + $urandom_range(2);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [3:0] c;
        int         r;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every command code from an empty start, then extremes and error cases
        for (int k = 0; k <= CMD_MAX; k++)
            send_command(4'(k), 0, 0);
        send_command(CMD_APPND, 32'sh7fffffff, 0);
        send_command(CMD_APPND, 32'sh80000000, 0);
        send_command(CMD_APPND, -1, 0);
        send_command(CMD_MEAN, 0, 0);
        send_command(CMD_MIN, 0, 0);
        send_command(CMD_MAX, 0, 0);
        send_command(CMD_FIND, -1, 0);
        send_command(CMD_FIND, 5, 0);
        send_command(CMD_REMI, 0, 63);
        send_command(CMD_REMI, 0, 1);
        send_command(CMD_LIST, 0, 0);
        send_command(4'd15, 0, 0);
        send_command(4'd9, 0, 0);
        // fill to capacity then overflow, all-ones position bits too
        for (int k = 0; k < CAP + 1; k++)
            send_command(CMD_APPND, 32'sh7fffffff, 6'h3f);
        send_command(CMD_MEAN, 0, 0);
        send_command(CMD_LIST, 0, 0);
        send_command(CMD_REMV, 32'sh7fffffff, 0);
        send_command(CMD_LIST, 0, 0);

        // random: appends weighted heavily so the list stays populated
        for (int k = 0; k < 100; k++)
        begin
            steady = (k >= 60 && k < 90);
            r = $urandom_range(99);
            if (r < 40)
                c = CMD_APPND;
            else if (r < 43)
                c = CMD_CLEAR;
            else if (r < 46)
                c = 4'($urandom_range(15, 9));
            else
                c = 4'($urandom_range(CMD_MAX));
            if (c == CMD_CLEAR && $urandom_range(1))
                c = CMD_LIST;
            send_command(c, pick_value(), 6'($urandom_range(board.fill + 2)));
        end
        in_valid <= 1'b0;
        steady = 0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end
endmodule
